// ----- src/ufu_pkg.sv -----
// Shared types and constants of the serial flash upload receiver.
// No dependencies; every module file imports it.
`default_nettype none

package ufu_pkg;

    localparam int PAGE_NUM_W = 24;
    localparam int LEN_BYTES  = 4;

    localparam logic [63:0] START_PATTERN_RST = 64'hA20C_6A11_F312_ED23;

    localparam logic [7:0] ACK_A = 8'h41;
    localparam logic [7:0] ACK_C = 8'h43;
    localparam logic [7:0] ACK_K = 8'h4B;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_PROG  = 2'd3
    } result_kind_t;

    // result sequence loaded by one input byte
    typedef enum logic [1:0] {
        BURST_ACK   = 2'd0,
        BURST_ERASE = 2'd1,
        BURST_DATA  = 2'd2,
        BURST_PROG  = 2'd3
    } burst_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_t;

    typedef struct packed {
        logic [63:0] start_pattern;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  byte_value;
        logic [7:0]  page_offset;
        logic [31:0] page_address;
        logic [8:0]  page_bytes;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } staged_t;

    typedef struct packed {
        burst_kind_t kind;
        logic [7:0]  data;
        logic [7:0]  offset;
        logic [31:0] address;
        logic [8:0]  count;
    } burst_t;

    function automatic logic [7:0] ack_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = ACK_A;
            2'd1:    c = ACK_C;
            default: c = ACK_K;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/ufu_chan_if.sv -----
// Valid/ready channel interface used for every channel port of the receiver.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface ufu_chan_if #(parameter type payload_t = logic [7:0]) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/ufu_in_stage.sv -----
// Input register of the receiver: holds one received byte until the step logic takes it.
// Depends on ufu_pkg and ufu_chan_if.
`default_nettype none

module ufu_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ufu_chan_if.sink              rx,
    input  wire logic             take,
    output ufu_pkg::staged_t      staged
);
    import ufu_pkg::*;

    logic       full_reg;
    logic       full_next;
    logic [7:0] data_reg;
    logic       rx_fire;

    assign rx.ready  = !full_reg || take;
    assign rx_fire   = rx.valid && rx.ready;

    always_comb
    begin
        priority if (rx_fire)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            data_reg <= rx.payload.rx_byte;
        end
    end

    assign staged.valid = full_reg;
    assign staged.data  = data_reg;

endmodule

`default_nettype wire

// ----- src/ufu_step.sv -----
// Session state machine: pattern match, length capture, page tracking per byte.
// Holds the start pattern register. Depends on ufu_pkg and ufu_chan_if.
`default_nettype none

module ufu_step #(
    parameter int PAGE_SIZE     = 256,
    parameter int PATTERN_BYTES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ufu_chan_if.sink              cfg,
    input  wire ufu_pkg::staged_t staged,
    input  wire logic             take,
    output ufu_pkg::burst_t       burst,
    output logic                  burst_valid
);
    import ufu_pkg::*;

    localparam int CNT_RAW = $clog2(PAGE_SIZE + 1);
    localparam int CNT_W   = (CNT_RAW > 4) ? CNT_RAW : 4;
    localparam int BASE_W  = PAGE_NUM_W + $clog2(PAGE_SIZE);
    localparam int DIFF_W  = ((BASE_W > 32) ? BASE_W : 32) + 1;

    mode_t                   mode_reg,    mode_next;
    logic [CNT_W-1:0]        cnt_reg,     cnt_next;
    logic [31:0]             len_reg,     len_next;
    logic [PAGE_NUM_W-1:0]   pn_reg,      pn_next;
    logic [BASE_W-1:0]       base_reg,    base_next;
    logic [63:0]             pattern_reg;

    logic [7:0]              b;
    logic [CNT_W-1:0]        cnt_inc;
    logic [4:0]              lane_sh;
    logic [31:0]             len_upd;
    logic                    len_done;
    logic                    page_full;
    logic                    page_short;
    logic [DIFF_W-1:0]       remain;
    logic [BASE_W-1:0]       base_adv;
    logic [63:0]             pat_shift;
    logic                    pat_hit;
    logic [CNT_W-1:0]        match_cnt;
    logic                    match_done;

    assign cfg.ready = 1'b1;
    assign b         = staged.data;

    // shared decode
    always_comb
    begin
        cnt_inc    = cnt_reg + CNT_W'(1);
        lane_sh    = {cnt_reg[1:0], 3'b000};
        len_upd    = (len_reg & ~(32'h0000_00FF << lane_sh)) | ({24'd0, b} << lane_sh);
        len_done   = cnt_inc >= CNT_W'(LEN_BYTES);
        page_full  = cnt_inc >= CNT_W'(PAGE_SIZE);
        remain     = DIFF_W'(len_reg) - DIFF_W'(base_reg);
        page_short = remain == DIFF_W'(cnt_inc);
        base_adv   = (pn_reg == {PAGE_NUM_W{1'b1}}) ? '0 : base_reg + BASE_W'(PAGE_SIZE);
        pat_shift  = pattern_reg >> {cnt_reg[2:0], 3'b000};
        pat_hit    = (cnt_reg < CNT_W'(PATTERN_BYTES)) && (b == pat_shift[7:0]);
        match_cnt  = pat_hit ? cnt_inc : '0;
        match_done = match_cnt >= CNT_W'(PATTERN_BYTES);
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        pn_next   = pn_reg;
        base_next = base_reg;
        unique case (mode_reg)
            MODE_LEN:
            begin
                len_next = len_upd;
                if (len_done)
                begin
                    cnt_next  = '0;
                    mode_next = (len_upd == 32'd0) ? MODE_IDLE : MODE_DATA;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            MODE_DATA:
            begin
                if (page_full)
                begin
                    cnt_next  = '0;
                    pn_next   = pn_reg + PAGE_NUM_W'(1);
                    base_next = base_adv;
                    if (len_reg == 32'(base_adv))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                else if (page_short)
                begin
                    cnt_next  = '0;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                if (match_done)
                begin
                    mode_next = MODE_LEN;
                    cnt_next  = '0;
                    pn_next   = '0;
                    base_next = '0;
                end
                else
                begin
                    cnt_next = match_cnt;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        burst.kind    = BURST_ACK;
        burst.data    = b;
        burst.offset  = 8'(cnt_reg);
        burst.address = 32'(base_reg);
        burst.count   = 9'(cnt_inc);
        burst_valid   = 1'b0;
        unique case (mode_reg)
            MODE_LEN:
            begin
                burst.kind  = BURST_ERASE;
                burst_valid = staged.valid && len_done;
            end
            MODE_DATA:
            begin
                burst.kind  = (page_full || page_short) ? BURST_PROG : BURST_DATA;
                burst_valid = staged.valid;
            end
            default:
            begin
                burst.kind  = BURST_ACK;
                burst_valid = staged.valid && match_done;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            cnt_reg     <= '0;
            len_reg     <= '0;
            pn_reg      <= '0;
            base_reg    <= '0;
            pattern_reg <= START_PATTERN_RST;
        end
        else
        begin
            if (take)
            begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                len_reg  <= len_next;
                pn_reg   <= pn_next;
                base_reg <= base_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                pattern_reg <= cfg.payload.start_pattern;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/ufu_out.sv -----
// Result register and sequencer: plays out the one to five results of a byte.
// Depends on ufu_pkg and ufu_chan_if.
`default_nettype none

module ufu_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ufu_pkg::burst_t burst,
    input  wire logic            load,
    ufu_chan_if.source           res,
    output logic                 free
);
    import ufu_pkg::*;

    burst_t     burst_reg;
    logic       busy_reg,  busy_next;
    logic [2:0] pos_reg,   pos_next;
    logic [2:0] last_pos;
    res_t       res_d;
    logic       res_fire;

    always_comb
    begin
        unique case (burst_reg.kind)
            BURST_ACK:   last_pos = 3'd2;
            BURST_ERASE: last_pos = 3'd3;
            BURST_DATA:  last_pos = 3'd0;
            default:     last_pos = 3'd4;
        endcase
    end

    always_comb
    begin
        res_d             = '0;
        res_d.result_kind = KIND_TX;
        unique case (burst_reg.kind)
            BURST_ACK:
            begin
                res_d.byte_value = ack_char(pos_reg[1:0]);
            end
            BURST_ERASE:
            begin
                if (pos_reg == 3'd0)
                begin
                    res_d.result_kind = KIND_ERASE;
                end
                else
                begin
                    res_d.byte_value = ack_char(2'(pos_reg - 3'd1));
                end
            end
            BURST_DATA:
            begin
                res_d.result_kind = KIND_DATA;
                res_d.byte_value  = burst_reg.data;
                res_d.page_offset = burst_reg.offset;
            end
            default:
            begin
                if (pos_reg == 3'd0)
                begin
                    res_d.result_kind = KIND_DATA;
                    res_d.byte_value  = burst_reg.data;
                    res_d.page_offset = burst_reg.offset;
                end
                else if (pos_reg == 3'd1)
                begin
                    res_d.result_kind  = KIND_PROG;
                    res_d.page_address = burst_reg.address;
                    res_d.page_bytes   = burst_reg.count;
                end
                else
                begin
                    res_d.byte_value = ack_char(2'(pos_reg - 3'd2));
                end
            end
        endcase
        res_d.last = pos_reg == last_pos;
    end

    assign res.valid   = busy_reg;
    assign res.payload = res_d;
    assign res_fire    = busy_reg && res.ready;
    assign free        = !busy_reg || (res.ready && res_d.last);

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        priority if (load)
        begin
            busy_next = 1'b1;
            pos_next  = 3'd0;
        end
        else if (res_fire)
        begin
            if (res_d.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

endmodule

`default_nettype wire

// ----- src/uart_flash_upload_receiver.sv -----
// An rx byte is held in the input register, then loaded into the result register for res.
// Results leave one per cycle while res is ready; a byte causes 0, 1, 3, 4 or 5 of them.
// Throughput: one byte per cycle if res is ready and a byte causes no or one data result;
// otherwise the next byte is stepped in the cycle the previous byte's last result leaves.
// Reset: rst_n asynchronous; session idle, counters cleared, start_pattern to its default.
`default_nettype none

module uart_flash_upload_receiver #(
    parameter int PAGE_SIZE     = 256,
    parameter int PATTERN_BYTES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ufu_chan_if.sink   rx,
    ufu_chan_if.source res,
    ufu_chan_if.sink   cfg
);
    import ufu_pkg::*;

    staged_t staged;
    burst_t  burst;
    logic    burst_valid;
    logic    out_free;
    logic    take;

    assign take = staged.valid && out_free;

    ufu_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .take   (take),
        .staged (staged)
    );

    ufu_step #(
        .PAGE_SIZE     (PAGE_SIZE),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .staged      (staged),
        .take        (take),
        .burst       (burst),
        .burst_valid (burst_valid)
    );

    ufu_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .burst (burst),
        .load  (take && burst_valid),
        .res   (res),
        .free  (out_free)
    );

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (take && burst_valid) |-> (!res.valid || (res.ready && res.payload.last)))
        else $error("result sequence overwritten before its last transfer");

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.payload.last && !(take && burst_valid))
        |=> !res.valid)
        else $error("results continue after last without a new byte");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |=> staged.valid)
        else $error("accepted byte not held in input register");
`endif

endmodule

`default_nettype wire
